// ===== sv/rmq_pkg.sv =====
// ============================================================================
// rmq_pkg
// Shared types and constants for the rotation-matrix-to-quaternion pipeline.
// ============================================================================
package rmq_pkg;

   // Fraction bits of the matrix and quaternion fixed-point format
   localparam int FRAC_BITS = 30;

   // Data width of the matrix ports and quaternion ports
   localparam int DATA_W = 32;

   // Width that holds any root argument or off-diagonal sum exactly
   localparam int A_W = (FRAC_BITS > 33) ? FRAC_BITS + 2 : 35;
   localparam int POS_W = $clog2(A_W);

   // The largest normalized magnitude lies in [2^30, 2^31)
   localparam int NRM_W = 31;
   localparam int NRM_TOP = NRM_W - 1;

   // Square root and divider: two result bits per stage
   localparam int SQ_ST = 16;
   localparam int DV_ST = 16;

   // 1.0 in the working width
   localparam logic signed [A_W-1:0] ONE_Q = {{(A_W-1){1'b0}}, 1'b1} << FRAC_BITS;

   // 1.0 saturated to the output width
   localparam logic [DATA_W-1:0] QW_ONE = (FRAC_BITS >= DATA_W - 1) ?
      {1'b0, {(DATA_W-1){1'b1}}} : ({{(DATA_W-1){1'b0}}, 1'b1} << FRAC_BITS);

   // Branch codes
   typedef enum logic [1:0] {
      BR_TRACE = 2'd0,
      BR_M00   = 2'd1,
      BR_M11   = 2'd2,
      BR_M22   = 2'd3
   } br_type;

   // Side information that travels with each transaction
   typedef struct packed {
      logic [3:0] neg;
      br_type     br;
      logic       bad;
   } tag_type;

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// ============================================================================
// rotation_matrix_to_quaternion
// Converts a 3x3 rotation matrix to a unit quaternion by Shepperd's method.
// ============================================================================
// A new matrix is taken on every clock cycle (busy is always low) and its
// quaternion appears on the rsp_ ports, strobed by rsp_valid for one cycle.
// The pipeline holds the 64-bit square root (16 stages of
// two root bits) followed by the four parallel 32-bit dividers (16 stages of
// two quotient bits), plus six front stages for branch selection,
// normalization and the sum of squares, and one output register. Results
// cannot be held off by the receiver; transactions come out in order.
// ============================================================================
module rotation_matrix_to_quaternion (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m00,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m01,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m02,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m10,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m11,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m12,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m20,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m21,
   input  logic signed [rmq_pkg::DATA_W-1:0] req_m22,
   output logic                              rsp_valid,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qw,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qx,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qy,
   output logic signed [rmq_pkg::DATA_W-1:0] rsp_qz,
   output logic [1:0]                        rsp_branch_taken,
   output logic                              rsp_bad_input
);
   import rmq_pkg::*;

   // Scale a 31-bit unit fraction to FRAC_BITS and saturate with sign
   function automatic logic [DATA_W-1:0] fin_value(input logic [31:0] p, input logic neg);
      logic [63:0] mag;
      logic [63:0] one64;
      begin
         one64 = 64'd1;
         if (FRAC_BITS >= 31) begin
            mag = {32'd0, p} << (FRAC_BITS - 31);
         end else begin
            mag = ({32'd0, p} + (one64 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
         end
         if (!neg) begin
            fin_value = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
         end else begin
            fin_value = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
         end
      end
   endfunction

   // Fully pipelined: never busy
   assign busy = 1'b0;

   logic accept;
   assign accept = start & ~busy;

   // ------------------------------------------------------------------------
   // Stage 1: branch select, root argument and component vector
   // ------------------------------------------------------------------------
   logic signed [A_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [A_W-1:0] tr, a_in;
   logic signed [A_W-1:0] v_in [4];
   br_type br_in;

   assign e00 = A_W'(req_m00);
   assign e01 = A_W'(req_m01);
   assign e02 = A_W'(req_m02);
   assign e10 = A_W'(req_m10);
   assign e11 = A_W'(req_m11);
   assign e12 = A_W'(req_m12);
   assign e20 = A_W'(req_m20);
   assign e21 = A_W'(req_m21);
   assign e22 = A_W'(req_m22);
   assign tr  = e00 + e11 + e22;

   always_comb begin
      if (tr > 0) begin
         br_in   = BR_TRACE;
         a_in    = ONE_Q + tr;
         v_in[0] = a_in;
         v_in[1] = e21 - e12;
         v_in[2] = e02 - e20;
         v_in[3] = e10 - e01;
      end else if (e00 > e11 && e00 > e22) begin
         br_in   = BR_M00;
         a_in    = ONE_Q + e00 - e11 - e22;
         v_in[0] = e21 - e12;
         v_in[1] = a_in;
         v_in[2] = e01 + e10;
         v_in[3] = e02 + e20;
      end else if (e11 > e22) begin
         br_in   = BR_M11;
         a_in    = ONE_Q + e11 - e00 - e22;
         v_in[0] = e02 - e20;
         v_in[1] = e01 + e10;
         v_in[2] = a_in;
         v_in[3] = e12 + e21;
      end else begin
         br_in   = BR_M22;
         a_in    = ONE_Q + e22 - e00 - e11;
         v_in[0] = e10 - e01;
         v_in[1] = e02 + e20;
         v_in[2] = e12 + e21;
         v_in[3] = a_in;
      end
   end

   logic                  s1_vld_ff;
   logic signed [A_W-1:0] s1_v_ff [4];
   br_type                s1_br_ff;
   logic                  s1_bad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_v_ff   <= v_in;
      s1_br_ff  <= br_in;
      s1_bad_ff <= (a_in <= 0);
   end

   // ------------------------------------------------------------------------
   // Stage 2: magnitudes, signs and largest magnitude
   // ------------------------------------------------------------------------
   logic [A_W-1:0] mag_in [4];
   logic [A_W-1:0] mx01, mx23, mx_in;
   tag_type        tag2_in;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         mag_in[i]      = s1_v_ff[i][A_W-1] ? (A_W'(0) - A_W'(s1_v_ff[i])) : A_W'(s1_v_ff[i]);
         tag2_in.neg[i] = s1_v_ff[i][A_W-1];
      end
      mx01        = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
      mx23        = (mag_in[2] > mag_in[3]) ? mag_in[2] : mag_in[3];
      mx_in       = (mx01 > mx23) ? mx01 : mx23;
      tag2_in.br  = s1_br_ff;
      tag2_in.bad = s1_bad_ff;
   end

   logic           s2_vld_ff;
   logic [A_W-1:0] s2_mag_ff [4];
   logic [A_W-1:0] s2_mx_ff;
   tag_type        s2_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_mag_ff <= mag_in;
      s2_mx_ff  <= mx_in;
      s2_tag_ff <= tag2_in;
   end

   // ------------------------------------------------------------------------
   // Stage 3: leading-one position of the largest magnitude
   // ------------------------------------------------------------------------
   logic [POS_W-1:0] pos_in;

   always_comb begin
      pos_in = '0;
      for (int b = 0; b < A_W; b++) begin
         if (s2_mx_ff[b]) begin
            pos_in = POS_W'(b);
         end
      end
   end

   logic             s3_vld_ff;
   logic [A_W-1:0]   s3_mag_ff [4];
   logic [POS_W-1:0] s3_pos_ff;
   tag_type          s3_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_mag_ff <= s2_mag_ff;
      s3_pos_ff <= pos_in;
      s3_tag_ff <= s2_tag_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 4: common shift so the largest lies in [2^30, 2^31)
   // ------------------------------------------------------------------------
   logic [NRM_W-1:0] nrm_in [4];
   logic [A_W-1:0]   shf_tmp [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (s3_pos_ff > POS_W'(NRM_TOP)) begin
            shf_tmp[i] = s3_mag_ff[i] >> (s3_pos_ff - POS_W'(NRM_TOP));
         end else begin
            shf_tmp[i] = s3_mag_ff[i] << (POS_W'(NRM_TOP) - s3_pos_ff);
         end
         nrm_in[i] = shf_tmp[i][NRM_W-1:0];
      end
   end

   logic             s4_vld_ff;
   logic [NRM_W-1:0] s4_u_ff [4];
   tag_type          s4_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_u_ff   <= nrm_in;
      s4_tag_ff <= s3_tag_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 5: squares
   // ------------------------------------------------------------------------
   logic               s5_vld_ff;
   logic [2*NRM_W-1:0] s5_sq_ff [4];
   logic [NRM_W-1:0]   s5_u_ff [4];
   tag_type            s5_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      for (int i = 0; i < 4; i++) begin
         s5_sq_ff[i] <= {{NRM_W{1'b0}}, s4_u_ff[i]} * {{NRM_W{1'b0}}, s4_u_ff[i]};
      end
      s5_u_ff   <= s4_u_ff;
      s5_tag_ff <= s4_tag_ff;
   end

   // ------------------------------------------------------------------------
   // Stage 6: sum of squares
   // ------------------------------------------------------------------------
   logic             s6_vld_ff;
   logic [63:0]      s6_n2_ff;
   logic [NRM_W-1:0] s6_u_ff [4];
   tag_type          s6_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_vld_ff <= 1'b0;
      end else begin
         s6_vld_ff <= s5_vld_ff;
      end
      s6_n2_ff  <= 64'(s5_sq_ff[0]) + 64'(s5_sq_ff[1]) + 64'(s5_sq_ff[2]) + 64'(s5_sq_ff[3]);
      s6_u_ff   <= s5_u_ff;
      s6_tag_ff <= s5_tag_ff;
   end

   // ------------------------------------------------------------------------
   // Square root: restoring, two root bits per stage
   // ------------------------------------------------------------------------
   logic             sq_vld_ff  [SQ_ST];
   logic [33:0]      sq_rem_ff  [SQ_ST];
   logic [31:0]      sq_root_ff [SQ_ST];
   logic [63:0]      sq_rad_ff  [SQ_ST];
   logic [NRM_W-1:0] sq_u_ff    [SQ_ST][4];
   tag_type          sq_tag_ff  [SQ_ST];

   for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
      logic             vld_prev;
      logic [33:0]      rem_prev;
      logic [31:0]      root_prev;
      logic [63:0]      rad_prev;
      logic [NRM_W-1:0] u_prev [4];
      tag_type          tag_prev;
      logic [33:0]      rem_in  [3];
      logic [31:0]      root_in [3];
      logic [35:0]      cand, trial;

      if (k == 0) begin : g_first
         assign vld_prev  = s6_vld_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = s6_n2_ff;
         assign u_prev    = s6_u_ff;
         assign tag_prev  = s6_tag_ff;
      end else begin : g_next
         assign vld_prev  = sq_vld_ff[k-1];
         assign rem_prev  = sq_rem_ff[k-1];
         assign root_prev = sq_root_ff[k-1];
         assign rad_prev  = sq_rad_ff[k-1];
         assign u_prev    = sq_u_ff[k-1];
         assign tag_prev  = sq_tag_ff[k-1];
      end

      // Two dependent root-bit steps
      always_comb begin
         rem_in[0]  = rem_prev;
         root_in[0] = root_prev;
         cand       = '0;
         trial      = '0;
         for (int j = 0; j < 2; j++) begin
            cand  = {rem_in[j], rad_prev[63-2*j -: 2]};
            trial = {2'b00, root_in[j], 2'b01};
            if (cand >= trial) begin
               rem_in[j+1]  = 34'(cand - trial);
               root_in[j+1] = {root_in[j][30:0], 1'b1};
            end else begin
               rem_in[j+1]  = cand[33:0];
               root_in[j+1] = {root_in[j][30:0], 1'b0};
            end
         end
      end

      // Four radicand bits consumed per stage
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else begin
            sq_vld_ff[k] <= vld_prev;
         end
         sq_rem_ff[k]  <= rem_in[2];
         sq_root_ff[k] <= root_in[2];
         sq_rad_ff[k]  <= rad_prev << 4;
         sq_u_ff[k]    <= u_prev;
         sq_tag_ff[k]  <= tag_prev;
      end
   end

   // ------------------------------------------------------------------------
   // Dividers: u * 2^31 / r, four lanes, two quotient bits per stage
   // ------------------------------------------------------------------------
   logic        dv_vld_ff [DV_ST];
   logic [31:0] dv_rem_ff [DV_ST][4];
   logic [31:0] dv_q_ff   [DV_ST][4];
   logic [31:0] dv_r_ff   [DV_ST];
   tag_type     dv_tag_ff [DV_ST];

   for (genvar k = 0; k < DV_ST; k++) begin : g_div
      logic        vld_prev;
      logic [31:0] rem_prev [4];
      logic [31:0] q_prev   [4];
      logic [31:0] r_prev;
      tag_type     tag_prev;
      logic [1:0]  bit_in   [4];
      logic [31:0] rem_in   [4][3];
      logic [31:0] q_in     [4][3];
      logic [32:0] cand;

      if (k == 0) begin : g_first
         tag_type tag0;
         always_comb begin
            tag0     = sq_tag_ff[SQ_ST-1];
            tag0.bad = sq_tag_ff[SQ_ST-1].bad | (sq_root_ff[SQ_ST-1] == '0);
            for (int i = 0; i < 4; i++) begin
               rem_prev[i] = {2'b00, sq_u_ff[SQ_ST-1][i][NRM_W-1:1]};
               q_prev[i]   = '0;
               bit_in[i]   = {sq_u_ff[SQ_ST-1][i][0], 1'b0};
            end
         end
         assign vld_prev = sq_vld_ff[SQ_ST-1];
         assign r_prev   = sq_root_ff[SQ_ST-1];
         assign tag_prev = tag0;
      end else begin : g_next
         always_comb begin
            for (int i = 0; i < 4; i++) begin
               rem_prev[i] = dv_rem_ff[k-1][i];
               q_prev[i]   = dv_q_ff[k-1][i];
               bit_in[i]   = 2'b00;
            end
         end
         assign vld_prev = dv_vld_ff[k-1];
         assign r_prev   = dv_r_ff[k-1];
         assign tag_prev = dv_tag_ff[k-1];
      end

      // Two restoring steps per lane
      always_comb begin
         cand = '0;
         for (int i = 0; i < 4; i++) begin
            rem_in[i][0] = rem_prev[i];
            q_in[i][0]   = q_prev[i];
            for (int j = 0; j < 2; j++) begin
               cand = {rem_in[i][j], bit_in[i][1-j]};
               if (cand >= {1'b0, r_prev}) begin
                  rem_in[i][j+1] = 32'(cand - {1'b0, r_prev});
                  q_in[i][j+1]   = {q_in[i][j][30:0], 1'b1};
               end else begin
                  rem_in[i][j+1] = cand[31:0];
                  q_in[i][j+1]   = {q_in[i][j][30:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else begin
            dv_vld_ff[k] <= vld_prev;
         end
         for (int i = 0; i < 4; i++) begin
            dv_rem_ff[k][i] <= rem_in[i][2];
            dv_q_ff[k][i]   <= q_in[i][2];
         end
         dv_r_ff[k]   <= r_prev;
         dv_tag_ff[k] <= tag_prev;
      end
   end

   // ------------------------------------------------------------------------
   // Output register: rescale, sign, identity on bad input
   // ------------------------------------------------------------------------
   logic              out_vld_ff;
   logic [DATA_W-1:0] out_q_ff [4];
   logic [1:0]        out_br_ff;
   logic              out_bad_ff;
   logic [DATA_W-1:0] out_q_in [4];
   tag_type           tag_last;

   assign tag_last = dv_tag_ff[DV_ST-1];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (tag_last.bad) begin
            out_q_in[i] = (i == 0) ? QW_ONE : '0;
         end else begin
            out_q_in[i] = fin_value(dv_q_ff[DV_ST-1][i], tag_last.neg[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= dv_vld_ff[DV_ST-1];
      end
      out_q_ff   <= out_q_in;
      out_br_ff  <= tag_last.br;
      out_bad_ff <= tag_last.bad;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_qw           = out_q_ff[0];
   assign rsp_qx           = out_q_ff[1];
   assign rsp_qy           = out_q_ff[2];
   assign rsp_qz           = out_q_ff[3];
   assign rsp_branch_taken = out_br_ff;
   assign rsp_bad_input    = out_bad_ff;

endmodule
